// ----- rtl/bfss_pkg.sv -----
// ============================================================================
// bfss_pkg
// Shared codes and controller/datapath interface types for the substring search.
// ============================================================================
`default_nettype none

package bfss_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_PATTERN = 2'd0;
    localparam op_t OP_TEXT    = 2'd1;
    localparam op_t OP_SEARCH  = 2'd2;

    typedef struct packed {
        logic app_pat;   // append symbol to pattern store
        logic app_txt;   // append symbol to text store
        logic start;     // load start position, clear compare pipe
        logic run;       // advance the compare walk one step
        logic capture;   // latch the search result
        logic out_load;  // move latched result into output register
    } bfss_cmd_t;

    typedef struct packed {
        logic done;      // walk finished this cycle, result valid
    } bfss_stat_t;

endpackage

`default_nettype wire

// ----- rtl/brute_force_substring_search_top.sv -----
// ============================================================================
// brute_force_substring_search_top
// Naive substring search over byte-loaded pattern and text stores.
// ============================================================================
//
//  channel  | dir | tdata (low bit up)                        | tuser
//  ---------+-----+-------------------------------------------+-----------
//  s_*      | in  | symbol[7:0], restart[8], start_pos[16:9]  | op[1:0]
//  m_*      | out | found[0], match_pos[8:1]                  | -
//
//  Load beats (op 0/1) append a byte; op 3 is dropped.
//  A search beat walks alignments from start_pos: per alignment it reads
//  and compares one byte pair at a time through a registered read, and a
//  mismatch flushes the read in flight; the single read port of each
//  store sets this.
//  s_tready is low while a search runs or its result waits for the output
//  register; loads are still taken while an earlier result sits on m_*.
//  rst_n is asynchronous, active low; it empties both strings. Store
//  contents are not cleared: only bytes below the current length are read.
//
`default_nettype none

module brute_force_substring_search_top
    import bfss_pkg::*;
#(
    parameter int MAX_LEN = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // symbol[7:0], restart[8], start_pos[16:9], pad
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // found[0], match_pos[8:1], pad
);

    bfss_cmd_t  cmd;
    bfss_stat_t stat;
    logic       found;
    logic [7:0] match_pos;

    bfss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bfss_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_symbol     (s_tdata[7:0]),
        .in_restart    (s_tdata[8]),
        .in_start_pos  (s_tdata[16:9]),
        .stat          (stat),
        .out_found     (found),
        .out_match_pos (match_pos)
    );

    assign m_tdata = {7'd0, match_pos, found};

endmodule

`default_nettype wire

// ----- rtl/bfss_dp.sv -----
// ============================================================================
// bfss_dp
// Pattern/text stores, length counters, compare walk and result registers.
// ============================================================================
`default_nettype none

module bfss_dp
    import bfss_pkg::*;
#(
    parameter int MAX_LEN = 255
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire bfss_cmd_t  cmd,
    input  wire logic [7:0] in_symbol,
    input  wire logic       in_restart,
    input  wire logic [7:0] in_start_pos,
    output bfss_stat_t      stat,
    output logic            out_found,
    output logic [7:0]      out_match_pos
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PW = ((LW + 1) > 9) ? (LW + 1) : 9;

    logic [7:0] pat_mem [MAX_LEN];
    logic [7:0] txt_mem [MAX_LEN];

    logic [LW-1:0] plen_reg, plen_next;
    logic [LW-1:0] tlen_reg, tlen_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [LW-1:0] kis_reg, kis_next;
    logic [LW-1:0] cmp_k_reg, cmp_k_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [7:0]    pat_q_reg, txt_q_reg;
    logic          hit_found_reg;
    logic [7:0]    hit_pos_reg;
    logic          out_found_reg;
    logic [7:0]    out_pos_reg;

    logic [LW-1:0] pat_base, txt_base;
    logic          pat_wr, txt_wr;
    logic          issue;
    logic [PW-1:0] txt_addr;
    logic          pos_over;
    logic          done_c;
    logic          found_c;

    // append addresses; restart empties the string first
    assign pat_base = in_restart ? '0 : plen_reg;
    assign txt_base = in_restart ? '0 : tlen_reg;
    assign pat_wr   = cmd.app_pat && (pat_base < LW'(MAX_LEN));
    assign txt_wr   = cmd.app_txt && (txt_base < LW'(MAX_LEN));

    assign txt_addr = pos_reg + PW'(kis_reg) - PW'(1);

    // alignment runs past the text: pos + plen - 1 > tlen
    assign pos_over = ((PW+1)'(pos_reg) + (PW+1)'(plen_reg)) > ((PW+1)'(tlen_reg) + (PW+1)'(1));

    always_comb
    begin
        pos_next       = pos_reg;
        kis_next       = kis_reg;
        cmp_k_next     = cmp_k_reg;
        cmp_valid_next = cmp_valid_reg;
        issue          = 1'b0;
        done_c         = 1'b0;
        found_c        = 1'b0;
        plen_next      = plen_reg;
        tlen_next      = tlen_reg;

        if (pat_wr)
        begin
            plen_next = pat_base + LW'(1);
        end
        if (txt_wr)
        begin
            tlen_next = txt_base + LW'(1);
        end

        if (cmd.start)
        begin
            pos_next       = (in_start_pos == 8'd0) ? PW'(1) : PW'(in_start_pos);
            kis_next       = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.run)
        begin
            if (plen_reg == '0)
            begin
                done_c  = 1'b1;
                found_c = 1'b1;
            end
            else if (cmp_valid_reg && (txt_q_reg != pat_q_reg))
            begin
                // mismatch: next alignment, drop the read in flight
                pos_next       = pos_reg + PW'(1);
                kis_next       = '0;
                cmp_valid_next = 1'b0;
            end
            else if (cmp_valid_reg && ((cmp_k_reg + LW'(1)) == plen_reg))
            begin
                done_c  = 1'b1;
                found_c = 1'b1;
            end
            else if (!cmp_valid_reg && (kis_reg == '0) && (pos_over || (pos_reg > PW'(255))))
            begin
                done_c = 1'b1;
            end
            else if (kis_reg < plen_reg)
            begin
                issue          = 1'b1;
                cmp_valid_next = 1'b1;
                cmp_k_next     = kis_reg;
                kis_next       = kis_reg + LW'(1);
            end
            else
            begin
                cmp_valid_next = 1'b0;
            end
        end
    end

    assign stat.done = done_c;

    always_ff @(posedge clk)
    begin
        if (pat_wr)
        begin
            pat_mem[pat_base[AW-1:0]] <= in_symbol;
        end
        if (issue)
        begin
            pat_q_reg <= pat_mem[kis_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (txt_wr)
        begin
            txt_mem[txt_base[AW-1:0]] <= in_symbol;
        end
        if (issue)
        begin
            txt_q_reg <= txt_mem[txt_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            tlen_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            tlen_reg      <= tlen_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        kis_reg   <= kis_next;
        cmp_k_reg <= cmp_k_next;
        if (cmd.capture)
        begin
            hit_found_reg <= found_c;
            hit_pos_reg   <= found_c ? pos_reg[7:0] : 8'd0;
        end
        if (cmd.out_load)
        begin
            out_found_reg <= hit_found_reg;
            out_pos_reg   <= hit_pos_reg;
        end
    end

    assign out_found     = out_found_reg;
    assign out_match_pos = out_pos_reg;

endmodule

`default_nettype wire

// ----- rtl/bfss_ctrl.sv -----
// ============================================================================
// bfss_ctrl
// Sequencer: input accept, search walk control, output register valid.
// ============================================================================
`default_nettype none

module bfss_ctrl
    import bfss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire op_t        in_op,
    output logic            out_valid,
    input  wire logic       out_ready,
    output bfss_cmd_t       cmd,
    input  wire bfss_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_HOLD   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_PATTERN: cmd.app_pat = 1'b1;
                        OP_TEXT:    cmd.app_txt = 1'b1;
                        OP_SEARCH:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.run = 1'b1;
                if (stat.done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for brute_force_substring_search_top.
// The bench loads pattern and text bytes over the input stream and issues
// search beats. A scoreboard class keeps its own copy of both strings,
// works out the first match for each accepted search, and compares each
// output beat with the oldest outstanding answer.
// ============================================================================

module tb;
    import bfss_pkg::*;

    localparam int MAX_LEN      = 255;
    localparam int RANDOM_BEATS = 100;
    localparam int LONG_HOLD    = 400;     // receiver hold-off, in cycles
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_PRINTS   = 60;
    localparam longint LIMIT_NS = 500_000_000;

    // tuser code that the block drops
    localparam op_t OP_UNUSED = 2'd3;

    typedef struct packed {
        logic       found;
        logic [7:0] match_pos;
    } search_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: string copies, search predictor, queue of pending answers.
    // ------------------------------------------------------------------------
    class search_scoreboard;
        logic [7:0]     pat_mem [MAX_LEN];
        logic [7:0]     txt_mem [MAX_LEN];
        int             pat_len;
        int             txt_len;
        search_result_t answers_q[$];
        int             errors;
        int             checked;

        function new();
            pat_len = 0;
            txt_len = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return answers_q.size();
        endfunction

        // Naive scan: every alignment from first, bail on first bad byte.
        function int find_first(int first);
            int pos;
            int k;
            for (pos = first; pos + pat_len <= txt_len + 1; pos++)
            begin
                for (k = 0; k < pat_len; k++)
                begin
                    if (txt_mem[pos - 1 + k] != pat_mem[k])
                        break;
                end
                if (k == pat_len)
                    return pos;
            end
            return 0;
        endfunction

        // Called for every accepted input beat.
        function void note_beat(op_t op, logic [7:0] sym, logic restart,
                                logic [7:0] start_pos);
            search_result_t res;
            int first;
            int hit;
            case (op)
                OP_PATTERN:
                begin
                    if (restart)
                        pat_len = 0;
                    if (pat_len < MAX_LEN)
                    begin
                        pat_mem[pat_len] = sym;
                        pat_len++;
                    end
                end
                OP_TEXT:
                begin
                    if (restart)
                        txt_len = 0;
                    if (txt_len < MAX_LEN)
                    begin
                        txt_mem[txt_len] = sym;
                        txt_len++;
                    end
                end
                OP_SEARCH:
                begin
                    // restart is don't-care here; start 0 means 1
                    first = (start_pos == 8'd0) ? 1 : int'(start_pos);
                    hit   = (pat_len == 0) ? first : find_first(first);
                    if (hit > 255)
                        hit = 0;
                    res.found     = (hit != 0);
                    res.match_pos = hit[7:0];
                    answers_q.push_back(res);
                end
                default: ;  // unused code, dropped
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_result(logic found, logic [7:0] match_pos);
            search_result_t want;
            checked++;
            if (answers_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat %0d with no search pending", checked));
                return;
            end
            want = answers_q.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("beat %0d found %b, want %b",
                                          checked, found, want.found));
            if (match_pos !== want.match_pos)
                report_mismatch($sformatf("beat %0d match_pos %0d, want %0d",
                                          checked, match_pos, want.match_pos));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals; all inputs known from time zero.
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // symbol[7:0], restart[8], start_pos[16:9], pad
    logic [1:0]  s_tuser  = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // found[0], match_pos[8:1], pad

    brute_force_substring_search_top #(
        .MAX_LEN (MAX_LEN)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    search_scoreboard sb = new();

    // stimulus/receiver coordination
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    bit quiet_tail     = 1'b0;
    int beats_sent     = 0;     // op 3 beats are not counted

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: covers big-store searches, the long hold and all stalls.
    initial
    begin
        #(LIMIT_NS);
        $display("brute_force_substring_search_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: sample at the edge, values are the pre-edge ones.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[0], m_tdata[8:1]);
    end

    // Receiver: random stall bursts, one long hold-off on request, none at
    // the tail.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
                m_tready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input-side drivers.
    // ------------------------------------------------------------------------

    // Random idle burst after a beat; valid is lowered only here and in
    // drain_results, so it is never dropped and raised in the same step.
    task automatic maybe_gap();
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Offer one beat and hold it until the handshake edge.
    task automatic send_beat(op_t op, logic [7:0] sym, logic restart,
                             logic [7:0] start_pos);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, start_pos, restart, sym};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(op, sym, restart, start_pos);
        if (op != OP_UNUSED)
            beats_sent++;
        maybe_gap();
    endtask

    // Stop offering and wait until every search has answered.
    task automatic drain_results();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic search(logic [7:0] start_pos);
        send_beat(OP_SEARCH, 8'($urandom), 1'($urandom), start_pos);
    endtask

    // One well-formed round: maybe new pattern, maybe new text, a few
    // searches. Small alphabets so matches and partial matches are common.
    task automatic run_round();
        logic [7:0] base;
        int         spread;
        int         n;
        int         k;
        int         hi;
        base   = 8'($urandom);
        spread = $urandom_range(0, 3);
        if ($urandom_range(0, 3) != 0)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                send_beat(OP_PATTERN, base ^ 8'($urandom_range(0, spread)),
                          (k == 0) && ($urandom_range(0, 9) != 0), 8'($urandom));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            n = $urandom_range(1, 40);
            for (k = 0; k < n; k++)
                send_beat(OP_TEXT, base ^ 8'($urandom_range(0, spread)),
                          (k == 0) && ($urandom_range(0, 9) != 0), 8'($urandom));
        end
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
        begin
            hi = (sb.txt_len + 2 > 255) ? 255 : sb.txt_len + 2;
            if ($urandom_range(0, 5) == 0)
                search(8'($urandom));
            else
                search(8'($urandom_range(0, hi)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int first_random;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // empty pattern answers the start itself, empty text or not
        search(8'd1);
        search(8'd0);                                   // start 0 acts as 1
        send_beat(OP_SEARCH, 8'hFF, 1'b1, 8'd255);      // restart ignored
        send_beat(OP_UNUSED, 8'hFF, 1'b1, 8'hFF);       // dropped
        send_beat(OP_PATTERN, "a", 1'b1, 8'd0);
        send_beat(OP_PATTERN, "b", 1'b0, 8'd0);
        search(8'd1);                                   // text shorter than pattern
        send_beat(OP_TEXT, "x", 1'b1, 8'd0);
        send_beat(OP_TEXT, "a", 1'b0, 8'd0);
        send_beat(OP_TEXT, "b", 1'b0, 8'd0);
        send_beat(OP_TEXT, "a", 1'b0, 8'd0);
        send_beat(OP_TEXT, "b", 1'b0, 8'd0);
        search(8'd1);
        search(8'd3);
        search(8'd5);                                   // pattern runs off the end
        search(8'd200);                                 // start beyond text
        search(8'd0);
        send_beat(OP_TEXT, 8'hFF, 1'b0, 8'hFF);
        send_beat(OP_TEXT, 8'h00, 1'b0, 8'hFF);
        send_beat(OP_PATTERN, 8'hFF, 1'b1, 8'hFF);
        send_beat(OP_PATTERN, 8'h00, 1'b0, 8'h00);
        search(8'd1);
        drain_results();

        // --- full stores: extra bytes are dropped, restart still empties ---
        for (i = 0; i < 260; i++)
            send_beat(OP_TEXT, 8'(i * 7), i == 0, 8'($urandom));
        for (i = 0; i < 258; i++)
            send_beat(OP_PATTERN, 8'(i * 7), i == 0, 8'($urandom));
        search(8'd1);                                   // whole store matches
        search(8'd2);
        for (i = 252; i < 255; i++)
            send_beat(OP_PATTERN, 8'(i * 7), i == 252, 8'($urandom));
        search(8'd1);                                   // tail of the text
        search(8'd253);
        search(8'd254);
        send_beat(OP_TEXT, 8'(252 * 7), 1'b1, 8'($urandom));
        search(8'd1);
        drain_results();

        // --- random rounds plus noise ---
        first_random = beats_sent;
        while (beats_sent - first_random < RANDOM_BEATS)
        begin
            if (!long_hold_req && beats_sent - first_random >= 30)
            begin
                // receiver stops; a burst of searches backs up the input
                long_hold_req = 1'b1;
                repeat (4) search(8'($urandom_range(0, 8)));
            end
            if (beats_sent - first_random >= RANDOM_BEATS - 25)
                quiet_tail = 1'b1;

            if ($urandom_range(0, 6) == 0)
                send_beat(op_t'($urandom_range(0, 3)), 8'($urandom),
                          1'($urandom), 8'($urandom));
            else
                run_round();

            if (!quiet_tail && $urandom_range(0, 19) == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("brute_force_substring_search_top regression: pass");
        else
            $display("brute_force_substring_search_top regression: fail");
        $finish;
    end

endmodule
